// File: rtl/ros_pkg.sv
// ray/oriented-box slab test: shared widths, register codes and types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ros_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int SLOT_W      = 16;
    localparam int UNIT_SHIFT  = 14;
    localparam int REG_W       = 3 * SLOT_W;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int NUM_REGS    = 5;

    localparam int DELTA_W = COORD_WIDTH + 1;
    localparam int EPROD_W = DELTA_W + SLOT_W;
    localparam int E_W     = EPROD_W + 2;
    localparam int FPROD_W = 2 * SLOT_W;
    localparam int F_W     = FPROD_W + 2;
    localparam int H_W     = COORD_WIDTH + UNIT_SHIFT;
    localparam int N_W     = E_W + 1;
    localparam int NUM_W   = N_W + UNIT_SHIFT;
    localparam int Q_W     = NUM_W;
    localparam int T_W     = Q_W + 2;
    localparam int DIST_W  = 15;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic signed [T_W-1:0] T_INF = {1'b0, {(T_W-1){1'b1}}};

    localparam logic [REG_W-1:0] AXIS_X_RST = REG_W'(64'd16384);
    localparam logic [REG_W-1:0] AXIS_Y_RST = REG_W'(64'd1073741824);
    localparam logic [REG_W-1:0] AXIS_Z_RST = REG_W'(64'd70368744177664);

    typedef enum logic [2:0] {
        REG_CENTER = 3'd0,
        REG_HALF   = 3'd1,
        REG_AXIS_X = 3'd2,
        REG_AXIS_Y = 3'd3,
        REG_AXIS_Z = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0]      center;
        logic [REG_W-1:0]      half;
        logic [2:0][REG_W-1:0] axis;
    } t_box;

    typedef struct packed {
        logic neg_hi;
        logic neg_lo;
        logic f_zero;
        logic in_slab;
    } t_axis_side;

    typedef struct packed {
        logic [N_W-1:0] n_hi_mag;
        logic [N_W-1:0] n_lo_mag;
        logic [F_W-1:0] f_mag;
        t_axis_side     side;
    } t_axis_req;

    typedef struct packed {
        logic signed [T_W-1:0] lo;
        logic signed [T_W-1:0] hi;
        logic                  miss;
    } t_ival;

endpackage
`default_nettype wire

// File: rtl/ros_if.sv
// request channels of the ray/box block: ray in, result out
// depends on ros_pkg
`timescale 1ns / 1ps
`default_nettype none
interface ros_ray_if;
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      origin_x;
    logic signed [15:0]      origin_y;
    logic signed [15:0]      origin_z;
    logic signed [15:0]      heading_x;
    logic signed [15:0]      heading_y;
    logic signed [15:0]      heading_z;
    modport source(output valid, origin_x, origin_y, origin_z, heading_x, heading_y,
                   heading_z, input ready);
    modport sink(input valid, origin_x, origin_y, origin_z, heading_x, heading_y,
                 heading_z, output ready);
endinterface

interface ros_res_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [ros_pkg::DIST_W-1:0]   distance;
    logic                         clipped;
    modport source(output valid, hit, distance, clipped, input ready);
    modport sink(input valid, hit, distance, clipped, output ready);
endinterface
`default_nettype wire

// File: rtl/ros_cfg.sv
// ray/box configuration registers behind an apb-style port
// depends on ros_pkg
`timescale 1ns / 1ps
`default_nettype none
module ros_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ros_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [ros_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [ros_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output ros_pkg::t_box                         o_box
);
    ros_pkg::t_box r_box;
    logic          wr;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ros_pkg::CFG_ADDR_W-1:3];
    assign o_box  = r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.center  <= '0;
            r_box.half    <= '0;
            r_box.axis[0] <= ros_pkg::AXIS_X_RST;
            r_box.axis[1] <= ros_pkg::AXIS_Y_RST;
            r_box.axis[2] <= ros_pkg::AXIS_Z_RST;
        end else if (wr) begin
            unique case (idx)
                ros_pkg::REG_CENTER: r_box.center  <= pwdata[ros_pkg::REG_W-1:0];
                ros_pkg::REG_HALF:   r_box.half    <= pwdata[ros_pkg::REG_W-1:0];
                ros_pkg::REG_AXIS_X: r_box.axis[0] <= pwdata[ros_pkg::REG_W-1:0];
                ros_pkg::REG_AXIS_Y: r_box.axis[1] <= pwdata[ros_pkg::REG_W-1:0];
                ros_pkg::REG_AXIS_Z: r_box.axis[2] <= pwdata[ros_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            ros_pkg::REG_CENTER: prdata[ros_pkg::REG_W-1:0] = r_box.center;
            ros_pkg::REG_HALF:   prdata[ros_pkg::REG_W-1:0] = r_box.half;
            ros_pkg::REG_AXIS_X: prdata[ros_pkg::REG_W-1:0] = r_box.axis[0];
            ros_pkg::REG_AXIS_Y: prdata[ros_pkg::REG_W-1:0] = r_box.axis[1];
            ros_pkg::REG_AXIS_Z: prdata[ros_pkg::REG_W-1:0] = r_box.axis[2];
            default: prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/ros_front.sv
// front pipeline: offsets, axis projections, slab numerators and magnitudes
// depends on ros_pkg
`timescale 1ns / 1ps
`default_nettype none
module ros_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [15:0]           i_origin [3],
    input  wire logic signed [15:0]           i_heading [3],
    input  ros_pkg::t_box                     i_box,
    output logic                              o_valid,
    output ros_pkg::t_axis_req [2:0]          o_req
);
    localparam int DW  = ros_pkg::DELTA_W;
    localparam int EPW = ros_pkg::EPROD_W;
    localparam int FPW = ros_pkg::FPROD_W;
    localparam int EW  = ros_pkg::E_W;
    localparam int FW  = ros_pkg::F_W;
    localparam int NW  = ros_pkg::N_W;
    localparam int HW  = ros_pkg::H_W;
    localparam int SW  = ros_pkg::SLOT_W;

    logic [3:0]               r_v;
    logic signed [DW-1:0]     r_delta [3];
    logic signed [15:0]       r_dir [3];
    logic signed [EPW-1:0]    r_pe [3][3];
    logic signed [FPW-1:0]    r_pf [3][3];
    logic signed [EW-1:0]     r_e [3];
    logic signed [FW-1:0]     r_f [3];
    logic [HW-1:0]            r_h [3];
    ros_pkg::t_axis_req [2:0] r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_delta[k] <= DW'($signed(i_box.center[SW*k +: SW])) - DW'(i_origin[k]);
                r_dir[k]   <= i_heading[k];
            end
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pe[j][k] <= EPW'($signed(i_box.axis[j][SW*k +: SW])) * EPW'(r_delta[k]);
                    r_pf[j][k] <= FPW'($signed(i_box.axis[j][SW*k +: SW])) * FPW'(r_dir[k]);
                end
                r_e[j] <= EW'(r_pe[j][0]) + EW'(r_pe[j][1]) + EW'(r_pe[j][2]);
                r_f[j] <= FW'(r_pf[j][0]) + FW'(r_pf[j][1]) + FW'(r_pf[j][2]);
                r_h[j] <= {i_box.half[SW*j +: SW], {ros_pkg::UNIT_SHIFT{1'b0}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                logic signed [NW-1:0] nh;
                logic signed [NW-1:0] nl;
                logic signed [NW-1:0] hs;
                logic                 fneg;
                hs   = NW'($signed({1'b0, r_h[j]}));
                nh   = NW'(r_e[j]) + hs;
                nl   = NW'(r_e[j]) - hs;
                fneg = r_f[j][FW-1];
                r_req[j].n_hi_mag     <= nh[NW-1] ? NW'(-nh) : nh;
                r_req[j].n_lo_mag     <= nl[NW-1] ? NW'(-nl) : nl;
                r_req[j].f_mag        <= fneg ? FW'(-r_f[j]) : r_f[j];
                r_req[j].side.neg_hi  <= nh[NW-1] ^ fneg;
                r_req[j].side.neg_lo  <= nl[NW-1] ^ fneg;
                r_req[j].side.f_zero  <= (r_f[j] == '0);
                r_req[j].side.in_slab <= (NW'(r_e[j]) > -hs) && (NW'(r_e[j]) < hs);
            end
        end
    end

    assign o_valid = r_v[3];
    assign o_req   = r_req;
endmodule
`default_nettype wire

// File: rtl/ros_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on ros_pkg
`timescale 1ns / 1ps
`default_nettype none
module ros_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [ros_pkg::NUM_W-1:0]  i_num,
    input  wire logic [ros_pkg::F_W-1:0]    i_den,
    output logic      [ros_pkg::Q_W-1:0]    o_quot
);
    localparam int QW = ros_pkg::Q_W;
    localparam int NW = ros_pkg::NUM_W;
    localparam int FW = ros_pkg::F_W;

    logic [FW-1:0] r_rem  [QW];
    logic [FW-1:0] r_den  [QW];
    logic [NW-1:0] r_num  [QW];
    logic [QW-1:0] r_quot [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            logic [FW-1:0] rem_in;
            logic [FW-1:0] den_in;
            logic [NW-1:0] num_in;
            logic [QW-1:0] quot_in;
            logic [FW:0]   trial;
            logic [FW:0]   diff;
            logic          take;
            if (s == 0) begin : g_first
                assign rem_in  = '0;
                assign den_in  = i_den;
                assign num_in  = i_num;
                assign quot_in = '0;
            end else begin : g_next
                assign rem_in  = r_rem[s-1];
                assign den_in  = r_den[s-1];
                assign num_in  = r_num[s-1];
                assign quot_in = r_quot[s-1];
            end
            assign trial = {rem_in, num_in[NW-1]};
            assign diff  = trial - {1'b0, den_in};
            assign take  = trial >= {1'b0, den_in};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= take ? diff[FW-1:0] : trial[FW-1:0];
                    r_den[s]  <= den_in;
                    r_num[s]  <= {num_in[NW-2:0], 1'b0};
                    r_quot[s] <= {quot_in[QW-2:0], take};
                end
            end
        end
    endgenerate

    assign o_quot = r_quot[QW-1];
endmodule
`default_nettype wire

// File: rtl/ray_obb_slab_intersection.sv
// ray against oriented box, slab test: top level with interval merge and output stage
// depends on ros_pkg, ros_if, ros_cfg, ros_front, ros_div
//
//   channel   dir   handshake     payload
//   i_ray     in    valid/ready   origin_x/y/z, heading_x/y/z
//   o_res     out   valid/ready   hit, distance, clipped
//   apb       in    psel/penable  box center, half extents, three axes
//
// one request per cycle while not held; pipeline of 4 front stages, 50 divider stages
// (one quotient bit each), 3 interval stages and the output register
// the whole pipeline holds while a result waits and o_res.ready is low
// synchronous active-low reset clears all valid bits, center and half; sets unit axes
`timescale 1ns / 1ps
`default_nettype none
module ray_obb_slab_intersection (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    ros_ray_if.sink                               i_ray,
    ros_res_if.source                             o_res,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ros_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [ros_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [ros_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    localparam int QW = ros_pkg::Q_W;
    localparam int TW = ros_pkg::T_W;

    ros_pkg::t_box                       box;
    logic                                en;
    logic signed [15:0]                  origin [3];
    logic signed [15:0]                  heading [3];
    logic                                f_valid;
    ros_pkg::t_axis_req [2:0]            f_req;
    logic [QW-1:0]                       q_hi [3];
    logic [QW-1:0]                       q_lo [3];

    logic [QW-1:0]                       r_dv;
    ros_pkg::t_axis_side [2:0]           r_ds [QW];

    logic [2:0]                          r_cv;
    ros_pkg::t_ival                      r_iv [3];
    logic signed [TW-1:0]                r_ta [3][3];
    logic signed [TW-1:0]                r_tb [3][3];
    ros_pkg::t_axis_side [2:0]           r_cs [3];

    logic                                r_out_valid;
    logic                                r_hit;
    logic [ros_pkg::DIST_W-1:0]          r_dist;
    logic                                r_clip;

    function automatic ros_pkg::t_ival axis_step(input ros_pkg::t_ival iv,
                                                 input logic signed [TW-1:0] ta,
                                                 input logic signed [TW-1:0] tb,
                                                 input ros_pkg::t_axis_side sd);
        ros_pkg::t_ival        o;
        logic signed [TW-1:0]  tmin;
        logic signed [TW-1:0]  tmax;
        o    = iv;
        tmin = (tb < ta) ? tb : ta;
        tmax = (tb < ta) ? ta : tb;
        if (sd.f_zero) begin
            o.miss = iv.miss || !sd.in_slab;
        end else begin
            o.lo   = (tmin > iv.lo) ? tmin : iv.lo;
            o.hi   = (tmax < iv.hi) ? tmax : iv.hi;
            o.miss = iv.miss || (o.hi < o.lo) || (o.hi <= 0);
        end
        return o;
    endfunction

    assign en          = !r_out_valid || o_res.ready;
    assign i_ray.ready = en;

    assign origin[0]  = i_ray.origin_x;
    assign origin[1]  = i_ray.origin_y;
    assign origin[2]  = i_ray.origin_z;
    assign heading[0] = i_ray.heading_x;
    assign heading[1] = i_ray.heading_y;
    assign heading[2] = i_ray.heading_z;

    ros_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_box   (box)
    );

    ros_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_ray.valid),
        .i_origin  (origin),
        .i_heading (heading),
        .i_box     (box),
        .o_valid   (f_valid),
        .o_req     (f_req)
    );

    genvar j;
    generate
        for (j = 0; j < 3; j++) begin : g_axis
            ros_div u_div_hi (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_num  ({f_req[j].n_hi_mag, {ros_pkg::UNIT_SHIFT{1'b0}}}),
                .i_den  (f_req[j].f_mag),
                .o_quot (q_hi[j])
            );
            ros_div u_div_lo (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_num  ({f_req[j].n_lo_mag, {ros_pkg::UNIT_SHIFT{1'b0}}}),
                .i_den  (f_req[j].f_mag),
                .o_quot (q_lo[j])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv        <= '0;
            r_cv        <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_dv        <= {r_dv[QW-2:0], f_valid};
            r_cv        <= {r_cv[1:0], r_dv[QW-1]};
            r_out_valid <= r_cv[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ds[0] <= {f_req[2].side, f_req[1].side, f_req[0].side};
            for (int s = 1; s < QW; s++) begin
                r_ds[s] <= r_ds[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ros_pkg::t_ival       init;
            logic signed [TW-1:0] ta [3];
            logic signed [TW-1:0] tb [3];
            logic signed [TW-1:0] dd;
            init.lo   = '0;
            init.hi   = ros_pkg::T_INF;
            init.miss = 1'b0;
            for (int k = 0; k < 3; k++) begin
                ta[k] = r_ds[QW-1][k].neg_hi ? -TW'(q_hi[k]) : TW'(q_hi[k]);
                tb[k] = r_ds[QW-1][k].neg_lo ? -TW'(q_lo[k]) : TW'(q_lo[k]);
            end
            r_iv[0] <= axis_step(init, ta[0], tb[0], r_ds[QW-1][0]);
            for (int k = 0; k < 3; k++) begin
                r_ta[0][k] <= ta[k];
                r_tb[0][k] <= tb[k];
            end
            r_cs[0] <= r_ds[QW-1];
            for (int s = 1; s < 3; s++) begin
                r_iv[s] <= axis_step(r_iv[s-1], r_ta[s-1][s], r_tb[s-1][s], r_cs[s-1][s]);
                for (int k = 0; k < 3; k++) begin
                    r_ta[s][k] <= r_ta[s-1][k];
                    r_tb[s][k] <= r_tb[s-1][k];
                end
                r_cs[s] <= r_cs[s-1];
            end
            dd = (r_iv[2].lo > 0) ? r_iv[2].lo : r_iv[2].hi;
            if (r_iv[2].miss) begin
                r_hit  <= 1'b0;
                r_dist <= '0;
                r_clip <= 1'b0;
            end else if (dd > TW'(ros_pkg::DIST_MAX)) begin
                r_hit  <= 1'b1;
                r_dist <= ros_pkg::DIST_MAX;
                r_clip <= 1'b1;
            end else begin
                r_hit  <= 1'b1;
                r_dist <= dd[ros_pkg::DIST_W-1:0];
                r_clip <= 1'b0;
            end
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.hit      = r_hit;
    assign o_res.distance = r_dist;
    assign o_res.clipped  = r_clip;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> o_res.distance == '0 && !o_res.clipped)
        else $error("miss result carries distance or clip");
    a_clip_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.clipped |-> o_res.hit && o_res.distance == ros_pkg::DIST_MAX)
        else $error("clipped result without saturated distance");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ray.ready == (!o_res.valid || o_res.ready))
        else $error("input ready does not follow output stall");
`endif
endmodule
`default_nettype wire

// File: sim/ros_result_checker.sv
// checker for the ray/oriented-box slab test: mirrors the box registers,
// predicts one result per accepted ray and compares it with o_res
// depends on ros_pkg and ros_if
`timescale 1ns / 1ps
module ros_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ros_ray_if                               ray,
    ros_res_if                               res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [ros_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ros_pkg::CFG_DATA_W-1:0]   pwdata,
    output int                               o_errors,
    output int                               o_pending
);
    typedef struct {
        logic                       hit;
        logic [ros_pkg::DIST_W-1:0] distance;
        logic                       clipped;
    } t_hit_result;

    localparam longint CROSS_CAP = 64'sd1 << 40;
    localparam longint NO_LIMIT  = 64'sd1 << 62;

    logic [ros_pkg::REG_W-1:0] box_regs [ros_pkg::NUM_REGS];
    t_hit_result               expected_hits [$];
    int                        errors;

    assign o_errors  = errors;
    assign o_pending = expected_hits.size();

    // n * 2^14 / f, magnitude truncated toward zero, integer part capped at 2^40
    function automatic longint slab_crossing(longint n, longint f);
        logic                 neg;
        longint unsigned      un, uf, q, r, m;
        neg = (n < 0) != (f < 0);
        un  = (n < 0) ? -n : n;
        uf  = (f < 0) ? -f : f;
        q   = un / uf;
        r   = un % uf;
        if (q > CROSS_CAP) begin
            q = CROSS_CAP;
            r = 0;
        end
        m = (q << 14) + ((r << 14) / uf);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic t_hit_result predict_slab_hit(logic signed [15:0] org [3],
                                                     logic signed [15:0] hd [3]);
        t_hit_result rr;
        longint      delta [3];
        longint      lo, hi, e, f, h, t1, t2, t, d;
        logic        miss;
        lo   = 0;
        hi   = NO_LIMIT;
        miss = 1'b0;
        for (int k = 0; k < 3; k++)
            delta[k] = longint'($signed(box_regs[ros_pkg::REG_CENTER][16*k +: 16]))
                       - longint'(org[k]);
        for (int j = 0; j < 3; j++) begin
            if (!miss) begin
                e = 0;
                f = 0;
                for (int k = 0; k < 3; k++) begin
                    e += longint'($signed(box_regs[ros_pkg::REG_AXIS_X + j][16*k +: 16]))
                         * delta[k];
                    f += longint'($signed(box_regs[ros_pkg::REG_AXIS_X + j][16*k +: 16]))
                         * longint'(hd[k]);
                end
                h = longint'({48'd0, box_regs[ros_pkg::REG_HALF][16*j +: 16]}) * 16384;
                if (f == 0) begin
                    if (!(e > -h && e < h))
                        miss = 1'b1;
                end else begin
                    t1 = slab_crossing(e + h, f);
                    t2 = slab_crossing(e - h, f);
                    if (t2 < t1) begin
                        t  = t1;
                        t1 = t2;
                        t2 = t;
                    end
                    if (t1 > lo)
                        lo = t1;
                    if (t2 < hi)
                        hi = t2;
                    if (hi < lo || hi <= 0)
                        miss = 1'b1;
                end
            end
        end
        rr = '{1'b0, '0, 1'b0};
        if (!miss) begin
            d          = (lo > 0) ? lo : hi;
            rr.hit     = 1'b1;
            rr.clipped = d > 32767;
            rr.distance = rr.clipped ? ros_pkg::DIST_MAX : d[ros_pkg::DIST_W-1:0];
        end
        return rr;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_hit_result        want;
        logic signed [15:0] org [3];
        logic signed [15:0] hd [3];
        if (!i_rst_n) begin
            box_regs[ros_pkg::REG_CENTER] <= '0;
            box_regs[ros_pkg::REG_HALF]   <= '0;
            box_regs[ros_pkg::REG_AXIS_X] <= ros_pkg::AXIS_X_RST;
            box_regs[ros_pkg::REG_AXIS_Y] <= ros_pkg::AXIS_Y_RST;
            box_regs[ros_pkg::REG_AXIS_Z] <= ros_pkg::AXIS_Z_RST;
            expected_hits.delete();
        end else begin
            if (psel && penable && pwrite && pready && (paddr >> 3) < ros_pkg::NUM_REGS)
                box_regs[paddr >> 3] <= pwdata[ros_pkg::REG_W-1:0];
            if (res.valid && res.ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result, hit", res.hit, -1);
                end else begin
                    want = expected_hits.pop_front();
                    if (res.hit !== want.hit)
                        report_mismatch("hit", res.hit, want.hit);
                    if (res.distance !== want.distance)
                        report_mismatch("distance", res.distance, want.distance);
                    if (res.clipped !== want.clipped)
                        report_mismatch("clipped", res.clipped, want.clipped);
                end
            end
            if (ray.valid && ray.ready) begin
                org = '{ray.origin_x, ray.origin_y, ray.origin_z};
                hd  = '{ray.heading_x, ray.heading_y, ray.heading_z};
                expected_hits.push_back(predict_slab_hit(org, hd));
            end
        end
    end

    initial errors = 0;
endmodule

// File: sim/tb_ray_obb_slab_intersection.sv
// testbench top for ray_obb_slab_intersection: drives rays, box registers and
// result stalls; checking is done by ros_result_checker
// depends on ros_pkg, ros_if, ros_result_checker and the block itself
`timescale 1ns / 1ps
module tb_ray_obb_slab_intersection;
    localparam int RAYS_PER_PHASE = 540;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int DRAIN_CYCLES   = 80;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ros_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ros_pkg::CFG_DATA_W-1:0] pwdata;
    logic [ros_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;
    int   errors, pending;
    int   cycles = 0;
    logic burst_mode, hold_req;

    ros_ray_if ray ();
    ros_res_if res ();

    ray_obb_slab_intersection uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ray(ray.sink), .o_res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ros_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .ray(ray), .res(res), .psel(psel),
        .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
        .pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_ray_obb_slab_intersection NOT OK");
            $finish;
        end
    end

    function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    task automatic write_box_reg(ros_pkg::t_reg_idx idx, logic [47:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ros_pkg::CFG_ADDR_W'(idx * 8);
        pwdata  = {16'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_box(logic [47:0] c, logic [47:0] h, logic [47:0] ax,
                            logic [47:0] ay, logic [47:0] az);
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        write_box_reg(ros_pkg::REG_CENTER, c);
        write_box_reg(ros_pkg::REG_HALF, h);
        write_box_reg(ros_pkg::REG_AXIS_X, ax);
        write_box_reg(ros_pkg::REG_AXIS_Y, ay);
        write_box_reg(ros_pkg::REG_AXIS_Z, az);
    endtask

    // source side: gap, then offer until accepted
    task automatic send_ray(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                            logic [15:0] hx, logic [15:0] hy, logic [15:0] hz);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            ray.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ray.origin_x  = ox;
        ray.origin_y  = oy;
        ray.origin_z  = oz;
        ray.heading_x = hx;
        ray.heading_y = hy;
        ray.heading_z = hz;
        ray.valid     = 1'b1;
        @(posedge i_clk);
        while (!ray.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_origin();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1, 2:    return 16'($urandom_range(0, 16384) - 8192);
            default: return 16'($urandom_range(0, 2048) - 1024);
        endcase
    endfunction

    function automatic logic [15:0] rand_heading();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'd0;
            2:       return 16'($urandom_range(0, 6) - 3);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic random_rays(int count);
        logic [15:0] ox, oy, oz;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            if (n == count / 2 && !hold_req)
                hold_req = 1'b1;
            ox = rand_origin();
            oy = rand_origin();
            oz = rand_origin();
            // aim roughly at the box most of the time
            if ($urandom_range(0, 3) != 0)
                send_ray(ox, oy, oz, -ox, -oy, -oz);
            else
                send_ray(ox, oy, oz, rand_heading(), rand_heading(), rand_heading());
        end
        ray.valid  = 1'b0;
        burst_mode = 1'b0;
    endtask

    // sink side: stall per result unless bursting, plus a long hold per random-ray phase
    initial begin
        res.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (!burst_mode) begin
                res.ready = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end
            res.ready = 1'b1;
            @(posedge i_clk);
            while (!res.valid) @(posedge i_clk);
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        burst_mode  = 1'b0;
        hold_req    = 1'b0;
        ray.valid   = 1'b0;
        ray.origin_x = '0;
        ray.origin_y = '0;
        ray.origin_z = '0;
        ray.heading_x = '0;
        ray.heading_y = '0;
        ray.heading_z = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset box: zero size, so a still ray misses
        send_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_ray(16'hF600, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        ray.valid = 1'b0;

        load_box(48'd0, pack3(16'h0A00, 16'h0A00, 16'h0A00), 48'd16384,
                 48'd1073741824, 48'd70368744177664);
        send_ray(16'hEC00, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_ray(16'h0100, 16'h0200, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_ray(16'h1400, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_ray(16'hEC00, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
        send_ray(16'h0A00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_ray(16'h09FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_ray(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_ray(16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
        send_ray(16'hEC00, 16'hEC00, 16'h0000, 16'h2D41, 16'h2D41, 16'h0000);
        send_ray(16'h0A00, 16'h0A00, 16'h0A00, 16'hC000, 16'h0000, 16'h0000);
        send_ray(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_ray(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
        ray.valid = 1'b0;
        random_rays(RAYS_PER_PHASE);

        // rotated box about z, off center
        load_box(pack3(16'h0300, 16'hFE00, 16'h0100), pack3(16'h0600, 16'h0200, 16'h0400),
                 pack3(16'd11585, 16'd11585, 16'd0), pack3(-16'sd11585, 16'd11585, 16'd0),
                 48'd70368744177664);
        random_rays(RAYS_PER_PHASE);

        // extremes: all ones, then axes of zero
        load_box({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
        random_rays(RAYS_PER_PHASE / 4);
        load_box(48'd0, {48{1'b1}}, 48'd0, 48'd0, 48'd0);
        random_rays(RAYS_PER_PHASE / 4);

        load_box({16'($urandom_range(0, 4096) - 2048), 16'($urandom_range(0, 4096) - 2048),
                  16'($urandom_range(0, 4096) - 2048)},
                 {16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                  16'($urandom_range(0, 4096))},
                 {16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom_range(0, 32768) - 16384)},
                 {16'($urandom), 16'($urandom), 16'($urandom)},
                 {16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom_range(0, 32768) - 16384)});
        random_rays(RAYS_PER_PHASE);

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("tb_ray_obb_slab_intersection OK");
        else
            $display("tb_ray_obb_slab_intersection NOT OK");
        $finish;
    end
endmodule
